// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro samples on clk; the plain form is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define HTLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("htlp assertion failed");

// Checked on every rising edge of clk, reset included.
`define HTLP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("htlp reset assertion failed");

`endif

// ===== rtl/core/htlp_pkg.sv =====
// Shared constants and controller/datapath interface types for the hash
// table insert block. No dependencies.
package htlp_pkg;

  localparam int DEFAULT_TABLE_SLOTS = 16;
  localparam int CHAR_W  = 8;
  localparam int FIELD_W = 4;
  localparam int TOTAL_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;  // write zero at the sweep pointer and advance
    logic take_byte;   // fold a non-final key byte into the running hash
    logic take_last;   // final byte: latch hash, start the probe
    logic step;        // slot occupied: advance the probe
    logic place;       // slot free: mark it and latch the result
    logic full;        // no free slot: latch a full result
    logic load_out;    // copy the latched result to the output registers
  } htlp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // sweep pointer at the last slot
    logic slot_free;   // slot under probe is free
    logic probe_last;  // this probe is the last slot left to try
  } htlp_status_t;

endpackage

// ===== rtl/core/htlp_ctrl.sv =====
// Controller state machine for the hash table insert block.
// Depends on htlp_pkg for the command and status types.
module htlp_ctrl import htlp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         key_valid,
  input  logic         key_end,
  output logic         key_stall,
  output logic         res_valid,
  input  logic         res_stall,
  input  htlp_status_t status,
  output htlp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !res_valid || !res_stall;
  assign key_stall = (state != S_IDLE);

  // Decode commands from state and handshake
  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      S_IDLE: begin
        if (key_valid) begin
          if (key_end) begin
            cmd.take_last = 1'b1;
          end else begin
            cmd.take_byte = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (status.slot_free) begin
          cmd.place = 1'b1;
        end else if (status.probe_last) begin
          cmd.full = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (status.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (key_valid && key_end) state <= S_PROBE;
        end
        S_PROBE: begin
          if (status.slot_free || status.probe_last) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/htlp_datapath.sv =====
// Datapath for the hash table insert block: additive hash, occupancy
// memory, probe pointer, collision total and output registers. Uses htlp_pkg.
module htlp_datapath import htlp_pkg::*; #(
  parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  htlp_cmd_t          cmd,
  input  logic [CHAR_W-1:0]  key_char,
  output htlp_status_t       status,
  output logic [FIELD_W-1:0] hash_slot,
  output logic [FIELD_W-1:0] placed_slot,
  output logic [FIELD_W-1:0] probe_collisions,
  output logic [TOTAL_W-1:0] total_collisions,
  output logic               table_full
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int CHARS  = 1 << CHAR_W;

  logic [SLOT_W-1:0]  char_mod [CHARS];
  logic [SLOT_W-1:0]  running_hash;
  logic [SLOT_W:0]    hash_sum;
  logic [SLOT_W-1:0]  hash_next;
  logic [SLOT_W-1:0]  ptr;
  logic [SLOT_W-1:0]  ptr_inc;
  logic [SLOT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   cnt;
  logic               rd_used;
  logic               slot_used [TABLE_SLOTS];
  logic               mem_we;
  logic               mem_wd;
  logic [SLOT_W-1:0]  hash_reg;
  logic [SLOT_W-1:0]  placed_reg;
  logic [CNT_W-1:0]   skip_reg;
  logic               full_reg;
  logic [TOTAL_W-1:0] collision_total;

  // Byte value reduced modulo the slot count, fixed at elaboration
  for (genvar i = 0; i < CHARS; i++) begin : g_char_mod
    assign char_mod[i] = SLOT_W'(i % TABLE_SLOTS);
  end

  // Add the reduced byte; the sum stays below twice the slot count
  always_comb begin
    hash_sum = {1'b0, running_hash} + {1'b0, char_mod[key_char]};
    if (hash_sum >= (SLOT_W + 1)'(TABLE_SLOTS)) begin
      hash_next = SLOT_W'(hash_sum - (SLOT_W + 1)'(TABLE_SLOTS));
    end else begin
      hash_next = SLOT_W'(hash_sum);
    end
  end

  // Next slot with wrap at the end of the map
  assign ptr_inc = (ptr == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : ptr + SLOT_W'(1);
  assign rd_addr = cmd.take_last ? hash_next : ptr_inc;

  assign mem_we = cmd.clear_step || cmd.place;
  assign mem_wd = cmd.place;

  assign status.clear_last = (ptr == SLOT_W'(TABLE_SLOTS - 1));
  assign status.slot_free  = !rd_used;
  assign status.probe_last = (cnt == CNT_W'(TABLE_SLOTS - 1));

  // Occupancy memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_used[ptr] <= mem_wd;
    end
    rd_used <= slot_used[rd_addr];
  end

  // Hold hash, pointer and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash    <= '0;
      ptr             <= '0;
      collision_total <= '0;
    end else begin
      if (cmd.take_byte) begin
        running_hash <= hash_next;
      end else if (cmd.take_last) begin
        running_hash <= '0;
      end
      if (cmd.take_last) begin
        ptr <= hash_next;
      end else if (cmd.clear_step || cmd.step) begin
        ptr <= ptr_inc;
      end
      if (cmd.place) begin
        collision_total <= collision_total + TOTAL_W'(cnt);
      end
    end
  end

  // Probe count and latched result
  always_ff @(posedge clk) begin
    if (cmd.take_last) begin
      cnt      <= '0;
      hash_reg <= hash_next;
    end else if (cmd.step) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.place) begin
      placed_reg <= ptr;
      skip_reg   <= cnt;
      full_reg   <= 1'b0;
    end else if (cmd.full) begin
      placed_reg <= '0;
      skip_reg   <= '0;
      full_reg   <= 1'b1;
    end
  end

  // Output registers, loaded when the result side can take a request
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hash_slot        <= FIELD_W'(hash_reg);
      placed_slot      <= FIELD_W'(placed_reg);
      probe_collisions <= FIELD_W'(skip_reg);
      total_collisions <= collision_total;
      table_full       <= full_reg;
    end
  end

endmodule

// ===== rtl/core/hash_table_linear_probe_insert.sv =====
// Hash table insert with linear probing over an occupancy map of TABLE_SLOTS
// slots. Key bytes are taken one per cycle while key_stall is low; a byte
// without key_end returns to the input at once. After a final byte the input
// stalls while the probe passes k occupied slots (at most TABLE_SLOTS - 1):
// the occupancy memory has one registered read port and the probe examines
// one slot per cycle, and then the result moves to the output registers. That
// last step waits while an earlier result is still held there by res_stall.
// A full table is probed at every slot and is flagged with nothing inserted.
// After reset a clearing pass zeroes the map while the input stalls. Depends
// on htlp_pkg, htlp_ctrl and htlp_datapath.
module hash_table_linear_probe_insert import htlp_pkg::*; #(
  parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_valid,
  output logic               key_stall,
  input  logic [CHAR_W-1:0]  key_char,
  input  logic               key_end,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [FIELD_W-1:0] hash_slot,
  output logic [FIELD_W-1:0] placed_slot,
  output logic [FIELD_W-1:0] probe_collisions,
  output logic [TOTAL_W-1:0] total_collisions,
  output logic               table_full
);

  htlp_cmd_t    cmd;
  htlp_status_t status;

  // Sequence the clear, byte, probe and emit steps
  htlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_end   (key_end),
    .key_stall (key_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hash, occupancy map and result registers
  htlp_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .key_char         (key_char),
    .status           (status),
    .hash_slot        (hash_slot),
    .placed_slot      (placed_slot),
    .probe_collisions (probe_collisions),
    .total_collisions (total_collisions),
    .table_full       (table_full)
  );

endmodule

// ===== rtl/core/htlp_checker.sv =====
// Port-level assertions for the hash table insert block, bound to the top.
// Depends on htlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module htlp_checker import htlp_pkg::*; #(
  parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
  input logic               clk,
  input logic               rst,
  input logic               key_valid,
  input logic               key_stall,
  input logic [CHAR_W-1:0]  key_char,
  input logic               key_end,
  input logic               res_valid,
  input logic               res_stall,
  input logic [FIELD_W-1:0] hash_slot,
  input logic [FIELD_W-1:0] placed_slot,
  input logic [FIELD_W-1:0] probe_collisions,
  input logic [TOTAL_W-1:0] total_collisions,
  input logic               table_full
);

  localparam logic NARROW = (TABLE_SLOTS <= (1 << FIELD_W));

  logic [FIELD_W:0]              walk_sum;
  logic [FIELD_W:0]              walk_slot;
  logic [3*FIELD_W+TOTAL_W:0]    res_word;

  // Expected placed slot: hash plus skipped slots, wrapped at the map end
  always_comb begin
    walk_sum = {1'b0, hash_slot} + {1'b0, probe_collisions};
    if (walk_sum >= (FIELD_W + 1)'(TABLE_SLOTS)) begin
      walk_slot = walk_sum - (FIELD_W + 1)'(TABLE_SLOTS);
    end else begin
      walk_slot = walk_sum;
    end
  end

  assign res_word = {hash_slot, placed_slot, probe_collisions, total_collisions, table_full};

  // A stalled key request holds its value
  `HTLP_ASSERT(a_key_hold, key_valid && key_stall |=> key_valid && $stable({key_char, key_end}))

  // A stalled result request holds its value
  `HTLP_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_word))

  // A full result carries no slot and no collisions
  `HTLP_ASSERT(a_full_zero, res_valid && table_full |-> {placed_slot, probe_collisions} == '0)

  // Placed slot lies the reported number of slots past the hash
  `HTLP_ASSERT(a_walk, res_valid && !table_full && NARROW |-> placed_slot == FIELD_W'(walk_slot))

  // Reset empties the result side and stalls input for the clearing pass
  `HTLP_ASSERT_RST(a_reset, rst |=> !res_valid && key_stall)

endmodule

bind hash_table_linear_probe_insert htlp_checker #(
  .TABLE_SLOTS (TABLE_SLOTS)
) u_htlp_checker (.*);
